// ----- rtl/assert_macros.svh -----
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication.
`define RV_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication.
`define RV_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`else

`define RV_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define RV_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ----- rtl/rvdec_pkg.sv -----
`default_nettype none

package rvdec_pkg;

	localparam logic [6:0] OPC_OP     = 7'h33;
	localparam logic [6:0] OPC_LOAD   = 7'h03;
	localparam logic [6:0] OPC_OPIMM  = 7'h13;
	localparam logic [6:0] OPC_STORE  = 7'h23;
	localparam logic [6:0] OPC_BRANCH = 7'h63;
	localparam logic [6:0] OPC_SYSTEM = 7'h73;
	localparam logic [6:0] OPC_FENCE  = 7'h0F;
	localparam logic [6:0] OPC_JALR   = 7'h67;
	localparam logic [6:0] OPC_JAL    = 7'h6F;
	localparam logic [6:0] OPC_AUIPC  = 7'h17;
	localparam logic [6:0] OPC_LUI    = 7'h37;

	localparam logic [6:0]  FUNCT7_ALT = 7'h20;
	localparam logic [11:0] SYS_IMM_EBREAK = 12'h001;

	typedef enum logic [2:0] {
		F3_0 = 3'd0, F3_1 = 3'd1, F3_2 = 3'd2, F3_3 = 3'd3,
		F3_4 = 3'd4, F3_5 = 3'd5, F3_6 = 3'd6, F3_7 = 3'd7
	} funct3_t;

	typedef enum logic [5:0] {
		MN_UNKNOWN = 6'd0,
		MN_LUI     = 6'd1,
		MN_AUIPC   = 6'd2,
		MN_JAL     = 6'd3,
		MN_JALR    = 6'd4,
		MN_BEQ     = 6'd5,
		MN_BNE     = 6'd6,
		MN_BLT     = 6'd7,
		MN_BGE     = 6'd8,
		MN_BLTU    = 6'd9,
		MN_BGEU    = 6'd10,
		MN_LB      = 6'd11,
		MN_LH      = 6'd12,
		MN_LW      = 6'd13,
		MN_LBU     = 6'd14,
		MN_LHU     = 6'd15,
		MN_SB      = 6'd16,
		MN_SH      = 6'd17,
		MN_SW      = 6'd18,
		MN_ADDI    = 6'd19,
		MN_SLTI    = 6'd20,
		MN_SLTIU   = 6'd21,
		MN_XORI    = 6'd22,
		MN_ORI     = 6'd23,
		MN_ANDI    = 6'd24,
		MN_SLLI    = 6'd25,
		MN_SRLI    = 6'd26,
		MN_SRAI    = 6'd27,
		MN_ADD     = 6'd28,
		MN_SUB     = 6'd29,
		MN_SLL     = 6'd30,
		MN_SLT     = 6'd31,
		MN_SLTU    = 6'd32,
		MN_XOR     = 6'd33,
		MN_SRL     = 6'd34,
		MN_SRA     = 6'd35,
		MN_OR      = 6'd36,
		MN_AND     = 6'd37,
		MN_FENCE   = 6'd38,
		MN_FENCE_I = 6'd39,
		MN_ECALL   = 6'd40,
		MN_EBREAK  = 6'd41,
		MN_CSRRW   = 6'd42,
		MN_CSRRS   = 6'd43,
		MN_CSRRC   = 6'd44,
		MN_CSRRWI  = 6'd45,
		MN_CSRRSI  = 6'd46,
		MN_CSRRCI  = 6'd47
	} mnemonic_t;

	function automatic mnemonic_t branch_code(input logic [2:0] f3);
		mnemonic_t m;
		unique case (funct3_t'(f3))
			F3_0:    m = MN_BEQ;
			F3_1:    m = MN_BNE;
			F3_4:    m = MN_BLT;
			F3_5:    m = MN_BGE;
			F3_6:    m = MN_BLTU;
			F3_7:    m = MN_BGEU;
			default: m = MN_UNKNOWN;
		endcase
		return m;
	endfunction

	function automatic mnemonic_t load_code(input logic [2:0] f3);
		mnemonic_t m;
		unique case (funct3_t'(f3))
			F3_0:    m = MN_LB;
			F3_1:    m = MN_LH;
			F3_2:    m = MN_LW;
			F3_4:    m = MN_LBU;
			F3_5:    m = MN_LHU;
			default: m = MN_UNKNOWN;
		endcase
		return m;
	endfunction

	function automatic mnemonic_t store_code(input logic [2:0] f3);
		mnemonic_t m;
		unique case (funct3_t'(f3))
			F3_0:    m = MN_SB;
			F3_1:    m = MN_SH;
			F3_2:    m = MN_SW;
			default: m = MN_UNKNOWN;
		endcase
		return m;
	endfunction

	function automatic mnemonic_t opimm_code(input logic [2:0] f3, input logic alt);
		mnemonic_t m;
		unique case (funct3_t'(f3))
			F3_0:    m = MN_ADDI;
			F3_1:    m = MN_SLLI;
			F3_2:    m = MN_SLTI;
			F3_3:    m = MN_SLTIU;
			F3_4:    m = MN_XORI;
			F3_5:    m = alt ? MN_SRAI : MN_SRLI;
			F3_6:    m = MN_ORI;
			default: m = MN_ANDI;
		endcase
		return m;
	endfunction

	function automatic mnemonic_t op_code(input logic [2:0] f3, input logic alt);
		mnemonic_t m;
		unique case (funct3_t'(f3))
			F3_0:    m = alt ? MN_SUB : MN_ADD;
			F3_1:    m = MN_SLL;
			F3_2:    m = MN_SLT;
			F3_3:    m = MN_SLTU;
			F3_4:    m = MN_XOR;
			F3_5:    m = alt ? MN_SRA : MN_SRL;
			F3_6:    m = MN_OR;
			default: m = MN_AND;
		endcase
		return m;
	endfunction

	function automatic mnemonic_t sys_code(input logic [2:0] f3, input logic is_ebreak);
		mnemonic_t m;
		unique case (funct3_t'(f3))
			F3_0:    m = is_ebreak ? MN_EBREAK : MN_ECALL;
			F3_1:    m = MN_CSRRW;
			F3_2:    m = MN_CSRRS;
			F3_3:    m = MN_CSRRC;
			F3_5:    m = MN_CSRRWI;
			F3_6:    m = MN_CSRRSI;
			F3_7:    m = MN_CSRRCI;
			default: m = MN_UNKNOWN;
		endcase
		return m;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/rv32i_instruction_decoder.sv -----
`default_nettype none
// Channel   Handshake            Payload
// command   start / busy         instr_word, instr_address
// result    done (strobe)        mnemonic .. target_address
//
// From the accepting edge to the done strobe there is one input register,
// then the decode and the target adder into the result register.
// One instruction per cycle is sustained; busy stays low.
// Async active-low reset clears the valid and strobe flags only.
// Results cannot be held off: each is shown for one cycle on done.

module rv32i_instruction_decoder
	import rvdec_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic        [31:0] instr_word,
	input  wire logic        [31:0] instr_address,
	output logic                    done,
	output logic             [5:0]  mnemonic,
	output logic             [4:0]  dest_reg,
	output logic             [4:0]  src_reg_a,
	output logic             [4:0]  src_reg_b,
	output logic signed      [31:0] immediate,
	output logic             [4:0]  shift_amount,
	output logic             [11:0] csr_number,
	output logic             [3:0]  fence_pred,
	output logic             [3:0]  fence_succ,
	output logic             [31:0] target_address
);

	logic        valid_s1;
	logic [31:0] word_s1;
	logic [31:0] addr_s1;

	logic [6:0]  opc;
	logic [2:0]  f3;
	logic        alt;
	logic [31:0] i_imm, s_imm, b_imm, j_imm, u_imm;

	mnemonic_t   code_c;
	logic [31:0] imm_c;
	logic [4:0]  shamt_c;
	logic [11:0] csr_c;
	logic [3:0]  pred_c, succ_c;
	logic        tgt_en_c;
	logic [31:0] tgt_sum_c;

	logic        done_q;
	mnemonic_t   code_q;
	logic [4:0]  rd_q, rs1_q, rs2_q, shamt_q;
	logic [31:0] imm_q, tgt_q;
	logic [11:0] csr_q;
	logic [3:0]  pred_q, succ_q;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			word_s1 <= instr_word;
			addr_s1 <= instr_address;
		end
	end

	assign opc   = word_s1[6:0];
	assign f3    = word_s1[14:12];
	assign alt   = (word_s1[31:25] == FUNCT7_ALT);
	assign i_imm = {{20{word_s1[31]}}, word_s1[31:20]};
	assign s_imm = {{20{word_s1[31]}}, word_s1[31:25], word_s1[11:7]};
	assign b_imm = {{19{word_s1[31]}}, word_s1[31], word_s1[7], word_s1[30:25],
		word_s1[11:8], 1'b0};
	assign j_imm = {{11{word_s1[31]}}, word_s1[31], word_s1[19:12], word_s1[20],
		word_s1[30:21], 1'b0};
	assign u_imm = {word_s1[31:12], 12'h000};

	always_comb begin
		code_c   = MN_UNKNOWN;
		imm_c    = '0;
		shamt_c  = '0;
		csr_c    = '0;
		pred_c   = '0;
		succ_c   = '0;
		tgt_en_c = 1'b0;
		unique case (opc)
			OPC_LUI: begin
				code_c = MN_LUI;
				imm_c  = u_imm;
			end
			OPC_AUIPC: begin
				code_c = MN_AUIPC;
				imm_c  = u_imm;
			end
			OPC_JAL: begin
				code_c   = MN_JAL;
				imm_c    = j_imm;
				tgt_en_c = 1'b1;
			end
			OPC_JALR: begin
				code_c = MN_JALR;
				imm_c  = i_imm;
			end
			OPC_BRANCH: begin
				code_c = branch_code(f3);
				if (code_c != MN_UNKNOWN) begin
					imm_c    = b_imm;
					tgt_en_c = 1'b1;
				end
			end
			OPC_LOAD: begin
				code_c = load_code(f3);
				if (code_c != MN_UNKNOWN) begin
					imm_c = i_imm;
				end
			end
			OPC_STORE: begin
				code_c = store_code(f3);
				if (code_c != MN_UNKNOWN) begin
					imm_c = s_imm;
				end
			end
			OPC_OPIMM: begin
				code_c = opimm_code(f3, alt);
				imm_c  = i_imm;
				if (f3 == F3_1 || f3 == F3_5) begin
					shamt_c = word_s1[24:20];
				end
			end
			OPC_OP: begin
				code_c = op_code(f3, alt);
			end
			OPC_FENCE: begin
				if (f3 == F3_0) begin
					code_c = MN_FENCE;
					imm_c  = i_imm;
					pred_c = word_s1[27:24];
					succ_c = word_s1[23:20];
				end else if (f3 == F3_1) begin
					code_c = MN_FENCE_I;
					imm_c  = i_imm;
				end
			end
			OPC_SYSTEM: begin
				code_c = sys_code(f3, word_s1[31:20] == SYS_IMM_EBREAK);
				if (code_c != MN_UNKNOWN) begin
					imm_c = i_imm;
					if (f3 != F3_0) begin
						csr_c = word_s1[31:20];
					end
				end
			end
			default: begin
				code_c = MN_UNKNOWN;
			end
		endcase
	end

	// wraps modulo 2^32
	assign tgt_sum_c = addr_s1 + imm_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			code_q  <= code_c;
			rd_q    <= word_s1[11:7];
			rs1_q   <= word_s1[19:15];
			rs2_q   <= word_s1[24:20];
			imm_q   <= imm_c;
			shamt_q <= shamt_c;
			csr_q   <= csr_c;
			pred_q  <= pred_c;
			succ_q  <= succ_c;
			tgt_q   <= tgt_en_c ? tgt_sum_c : 32'h0;
		end
	end

	assign done           = done_q;
	assign mnemonic       = code_q;
	assign dest_reg       = rd_q;
	assign src_reg_a      = rs1_q;
	assign src_reg_b      = rs2_q;
	assign immediate      = $signed(imm_q);
	assign shift_amount   = shamt_q;
	assign csr_number     = csr_q;
	assign fence_pred     = pred_q;
	assign fence_succ     = succ_q;
	assign target_address = tgt_q;

`include "assert_macros.svh"

	`RV_ASSERT_NXT(a_accept_to_done, clk, arst_n, start && !busy, ##1 done)
	`RV_ASSERT_IMP(a_done_has_source, clk, arst_n, done, $past(valid_s1))
	`RV_ASSERT_IMP(a_unknown_is_clean, clk, arst_n, done && mnemonic == MN_UNKNOWN, immediate == 32'sd0 && target_address == 32'h0 && csr_number == 12'h0)
	`RV_ASSERT_IMP(a_target_only_flow, clk, arst_n, done && target_address != 32'h0, mnemonic == MN_JAL || (mnemonic >= MN_BEQ && mnemonic <= MN_BGEU))

endmodule

`default_nettype wire
